[rtl/mmk_pkg.sv]
// Package for the Morse message keyer: item types, codes, keyer phases
// and the Morse pattern lookup. No dependencies.
`timescale 1ns / 1ps

package mmk_pkg;

  localparam int MSG_DEPTH = 64;
  localparam int MSG_AW    = $clog2(MSG_DEPTH);
  localparam int IDX_W     = 6;
  localparam int CHR_W     = 8;
  localparam int TCK_W     = 3;

  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_RESTART = 2'd1;
  localparam logic [1:0] ACT_TICK    = 2'd2;

  localparam logic [TCK_W-1:0] DOT_TICKS  = 3'd1;
  localparam logic [TCK_W-1:0] DASH_TICKS = 3'd3;
  localparam logic [TCK_W-1:0] CHAR_GAP   = 3'd3;
  localparam logic [TCK_W-1:0] WORD_GAP   = 3'd7 - CHAR_GAP;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_RESTART,
    OP_TICK,
    OP_NONE
  } op_t;

  typedef enum logic [1:0] {
    PH_FETCH,
    PH_START,
    PH_SOUND,
    PH_GAP
  } phase_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic [CHR_W-1:0] val;
  } entry_t;

  // Folds lower case and returns the marker-prefixed pattern, zero if unmapped.
  function automatic logic [CHR_W-1:0] morse_code(input logic [CHR_W-1:0] ch);
    logic [CHR_W-1:0] c;
    logic [CHR_W-1:0] code;
    begin
      c = ch;
      if (c >= 8'h61 && c <= 8'h7A) begin
        c = c - 8'h20;
      end
      case (c)
        8'h22: code = 8'h52;
        8'h27: code = 8'h5E;
        8'h28: code = 8'h36;
        8'h29: code = 8'h6D;
        8'h2B: code = 8'h2A;
        8'h2C: code = 8'h73;
        8'h2D: code = 8'h61;
        8'h2E: code = 8'h55;
        8'h2F: code = 8'h32;
        8'h30: code = 8'h3F;
        8'h31: code = 8'h2F;
        8'h32: code = 8'h27;
        8'h33: code = 8'h23;
        8'h34: code = 8'h21;
        8'h35: code = 8'h20;
        8'h36: code = 8'h30;
        8'h37: code = 8'h38;
        8'h38: code = 8'h3C;
        8'h39: code = 8'h3E;
        8'h3A: code = 8'h78;
        8'h3D: code = 8'h31;
        8'h3F: code = 8'h4C;
        8'h40: code = 8'h5A;
        8'h41: code = 8'h05;
        8'h42: code = 8'h18;
        8'h43: code = 8'h1A;
        8'h44: code = 8'h0C;
        8'h45: code = 8'h02;
        8'h46: code = 8'h12;
        8'h47: code = 8'h0E;
        8'h48: code = 8'h10;
        8'h49: code = 8'h04;
        8'h4A: code = 8'h17;
        8'h4B: code = 8'h0D;
        8'h4C: code = 8'h14;
        8'h4D: code = 8'h07;
        8'h4E: code = 8'h06;
        8'h4F: code = 8'h0F;
        8'h50: code = 8'h16;
        8'h51: code = 8'h1D;
        8'h52: code = 8'h0A;
        8'h53: code = 8'h08;
        8'h54: code = 8'h03;
        8'h55: code = 8'h09;
        8'h56: code = 8'h11;
        8'h57: code = 8'h0B;
        8'h58: code = 8'h19;
        8'h59: code = 8'h1B;
        8'h5A: code = 8'h1C;
        default: code = 8'h00;
      endcase
      return code;
    end
  endfunction

  // Element count: position of the marker bit, at least one.
  function automatic logic [TCK_W-1:0] morse_len(input logic [CHR_W-1:0] code);
    logic [TCK_W-1:0] len;
    begin
      len = 3'd1;
      for (int i = 2; i <= 6; i++) begin
        if (code[i]) begin
          len = TCK_W'(i);
        end
      end
      return len;
    end
  endfunction

endpackage

[rtl/mmk_if.sv]
// Channel interfaces of the Morse message keyer: input items and results.
// Depends on mmk_pkg.
`timescale 1ns / 1ps

interface mmk_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic [mmk_pkg::IDX_W-1:0] char_index;
  logic [mmk_pkg::CHR_W-1:0] char_value;

  modport source (output valid, output action, output char_index, output char_value,
                  input ready);
  modport sink (input valid, input action, input char_index, input char_value,
                output ready);
endinterface

interface mmk_out_if;
  logic                     valid;
  logic                     ready;
  logic                     key_down;
  logic [mmk_pkg::IDX_W-1:0] message_pos;

  modport source (output valid, output key_down, output message_pos, input ready);
  modport sink (input valid, input key_down, input message_pos, output ready);
endinterface

[rtl/mmk_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module mmk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/mmk_front.sv]
// Front end: takes input transactions and decodes the action into an op.
// Depends on mmk_pkg and mmk_if.
`timescale 1ns / 1ps

module mmk_front (
  mmk_in_if.sink           in_ch,
  output logic             push_valid,
  input  logic             push_ready,
  output mmk_pkg::entry_t  push_entry
);

  mmk_pkg::op_t op;

  always_comb begin
    case (in_ch.action)
      mmk_pkg::ACT_WRITE:   op = mmk_pkg::OP_WRITE;
      mmk_pkg::ACT_RESTART: op = mmk_pkg::OP_RESTART;
      mmk_pkg::ACT_TICK:    op = mmk_pkg::OP_TICK;
      default:              op = mmk_pkg::OP_NONE;
    endcase
  end

  assign push_valid      = in_ch.valid;
  assign in_ch.ready     = push_ready;
  assign push_entry.op   = op;
  assign push_entry.idx  = in_ch.char_index;
  assign push_entry.val  = in_ch.char_value;

endmodule

[rtl/mmk_queue.sv]
// Two-entry queue between the front end and the keyer back end.
// Depends on mmk_pkg.
`timescale 1ns / 1ps

module mmk_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  mmk_pkg::entry_t  push_entry,
  output logic             pop_valid,
  input  logic             pop_ready,
  output mmk_pkg::entry_t  pop_entry
);

  mmk_pkg::entry_t slot_r [2];
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      count_r;
  logic            push;
  logic            pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_entry  = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

[rtl/mmk_back.sv]
// Back end: message store, keyer phase machine and result register.
// Depends on mmk_pkg, mmk_if and mmk_ram.
`timescale 1ns / 1ps

module mmk_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  mmk_pkg::entry_t  pop_entry,
  mmk_out_if.source        out_ch
);

  localparam int AW = mmk_pkg::MSG_AW;
  localparam int TW = mmk_pkg::TCK_W;
  localparam int CW = mmk_pkg::CHR_W;

  mmk_pkg::phase_t       phase_r, phase_nxt;
  logic [TW-1:0]         tc_r, tc_nxt;
  logic [TW-1:0]         el_r, el_nxt;
  logic [CW-1:0]         pat_r, pat_nxt;
  logic                  key_r, key_nxt;
  logic [AW-1:0]         rp_r, rp_nxt;
  logic [CW-1:0]         cur_r, cur_nxt;
  logic                  pend_r, pend_nxt;
  logic                  rvalid_r;
  logic [CW-1:0]         head_r, head_nxt;
  logic [mmk_pkg::MSG_DEPTH-1:0] valid_r;
  logic                  out_valid_r;
  logic                  out_key_r;
  logic [mmk_pkg::IDX_W-1:0] out_pos_r;

  logic                  take;
  logic                  wr_en;
  logic [AW-1:0]         waddr;
  logic                  rd_en;
  logic [CW-1:0]         rdata;
  logic [CW-1:0]         cur_char;
  logic [CW-1:0]         fch;
  logic [CW-1:0]         code;
  logic [TW-1:0]         len;
  logic [AW-1:0]         rp_eff;
  logic                  done;

  mmk_ram #(
    .WIDTH (CW),
    .DEPTH (mmk_pkg::MSG_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (waddr),
    .wdata (pop_entry.val),
    .re    (rd_en),
    .raddr (rp_nxt),
    .rdata (rdata)
  );

  assign pop_ready = !out_valid_r || out_ch.ready;
  assign take      = pop_valid && pop_ready;
  assign waddr     = AW'(pop_entry.idx);
  assign cur_char  = pend_r ? (rvalid_r ? rdata : '0) : cur_r;

  always_comb begin
    phase_nxt = phase_r;
    tc_nxt    = tc_r;
    el_nxt    = el_r;
    pat_nxt   = pat_r;
    key_nxt   = key_r;
    rp_nxt    = rp_r;
    cur_nxt   = cur_char;
    pend_nxt  = 1'b0;
    head_nxt  = head_r;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    fch       = '0;
    code      = '0;
    len       = '0;
    rp_eff    = rp_r;
    done      = 1'b0;
    if (take) begin
      case (pop_entry.op)
        mmk_pkg::OP_WRITE: begin
          if (32'(pop_entry.idx) < mmk_pkg::MSG_DEPTH) begin
            wr_en = 1'b1;
            if (waddr == '0) begin
              head_nxt = pop_entry.val;
            end
            if (waddr == rp_r) begin
              cur_nxt = pop_entry.val;
            end
          end
        end
        mmk_pkg::OP_RESTART: begin
          rp_nxt    = '0;
          phase_nxt = mmk_pkg::PH_FETCH;
          cur_nxt   = head_r;
        end
        mmk_pkg::OP_TICK: begin
          if (phase_nxt == mmk_pkg::PH_FETCH) begin
            // zero byte ends the message: fetch from the start instead
            if (cur_char == '0) begin
              rp_eff = '0;
              fch    = head_r;
            end else begin
              fch    = cur_char;
            end
            rp_nxt   = (32'(rp_eff) == mmk_pkg::MSG_DEPTH - 1) ? '0 : rp_eff + 1'b1;
            rd_en    = 1'b1;
            pend_nxt = 1'b1;
            code     = mmk_pkg::morse_code(fch);
            if (code == '0) begin
              tc_nxt    = mmk_pkg::WORD_GAP - 3'd2;
              el_nxt    = '0;
              phase_nxt = mmk_pkg::PH_GAP;
              done      = 1'b1;
            end else begin
              len       = mmk_pkg::morse_len(code);
              pat_nxt   = CW'(16'(code) << (4'd8 - 4'(len)));
              el_nxt    = len;
              phase_nxt = mmk_pkg::PH_START;
            end
          end
          if (!done && phase_nxt == mmk_pkg::PH_START) begin
            tc_nxt    = pat_nxt[CW-1] ? mmk_pkg::DASH_TICKS : mmk_pkg::DOT_TICKS;
            pat_nxt   = {pat_nxt[CW-2:0], 1'b0};
            el_nxt    = el_nxt - 1'b1;
            key_nxt   = 1'b1;
            phase_nxt = mmk_pkg::PH_SOUND;
          end
          if (!done && phase_nxt == mmk_pkg::PH_SOUND) begin
            if (tc_nxt != '0) begin
              tc_nxt = tc_nxt - 1'b1;
              done   = 1'b1;
            end else begin
              phase_nxt = mmk_pkg::PH_GAP;
              tc_nxt    = (el_nxt != '0) ? mmk_pkg::DOT_TICKS - 3'd1
                                         : mmk_pkg::CHAR_GAP - 3'd1;
              key_nxt   = 1'b0;
            end
          end
          if (!done && phase_nxt == mmk_pkg::PH_GAP) begin
            if (tc_nxt == '0) begin
              phase_nxt = (el_nxt != '0) ? mmk_pkg::PH_START : mmk_pkg::PH_FETCH;
            end else begin
              tc_nxt = tc_nxt - 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= mmk_pkg::PH_FETCH;
      tc_r        <= '0;
      el_r        <= '0;
      pat_r       <= '0;
      key_r       <= 1'b0;
      rp_r        <= '0;
      cur_r       <= '0;
      pend_r      <= 1'b0;
      head_r      <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        phase_r <= phase_nxt;
        tc_r    <= tc_nxt;
        el_r    <= el_nxt;
        pat_r   <= pat_nxt;
        key_r   <= key_nxt;
        rp_r    <= rp_nxt;
        cur_r   <= cur_nxt;
        pend_r  <= pend_nxt;
        head_r  <= head_nxt;
      end
      if (wr_en) begin
        valid_r[waddr] <= 1'b1;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rvalid_r <= valid_r[rp_nxt];
    end
    if (take) begin
      out_key_r <= key_nxt;
      out_pos_r <= mmk_pkg::IDX_W'(rp_nxt);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.key_down    = out_key_r;
  assign out_ch.message_pos = out_pos_r;

endmodule

[rtl/morse_message_keyer.sv]
// Top level of the Morse message keyer: front end, queue and back end.
// Depends on mmk_pkg, mmk_if, mmk_front, mmk_queue, mmk_back.
`timescale 1ns / 1ps

// Repeating Morse beacon keyer. Write transactions fill a 64-byte message
// store (zero byte ends the message), restart transactions return to the
// first character, and each tick transaction advances the keyer by one time
// unit; every transaction returns one result with the key level and the
// next read position. One transaction is taken per clock cycle while the
// result is not stalled; a result passes through the queue entry, then the
// result register, and the back end computes each tick update combinationally.
// The message store is a RAM whose next character is prefetched after each
// fetch; one valid flag per entry makes unwritten entries read as zero, so
// no clearing pass is needed after reset.
module morse_message_keyer (
  input  logic        clk,
  input  logic        rst_n,
  mmk_in_if.sink      in_ch,
  mmk_out_if.source   out_ch
);

  logic            push_valid;
  logic            push_ready;
  mmk_pkg::entry_t push_entry;
  logic            pop_valid;
  logic            pop_ready;
  mmk_pkg::entry_t pop_entry;

  mmk_front u_front (
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  mmk_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  mmk_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .out_ch    (out_ch)
  );

endmodule

[rtl/mmk_checker.sv]
// Port-level checks for the Morse message keyer, bound to the top level.
// Depends on morse_message_keyer.
`timescale 1ns / 1ps

module mmk_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_key_down,
  input logic [5:0] out_message_pos
);

  logic [2:0] pend_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {2'b0, in_acc} - {2'b0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key_down)
                               && $stable(out_message_pos))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 3'd0)
    else $error("result without an outstanding transaction");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd3)
    else $error("more transactions in flight than storage");

endmodule

bind morse_message_keyer mmk_checker u_mmk_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_key_down    (out_ch.key_down),
  .out_message_pos (out_ch.message_pos)
);

[verif/morse_message_keyer_tb.sv]
// Self-checking testbench for morse_message_keyer: drives message writes, restarts and
// ticks, predicts key level and read position per transaction, and checks every result.
// Depends on mmk_pkg, mmk_if and the keyer RTL.
`timescale 1ns / 1ps

module morse_message_keyer_tb;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 12;
  localparam int TARGET_CMDS   = 1000;

  // Marker-prefixed patterns for 0x22..0x5A, first entry in the top byte.
  localparam logic [57*8-1:0] MORSE_PATTERNS = {
    8'h52, 8'h00, 8'h00, 8'h00, 8'h00, 8'h5E, 8'h36, 8'h6D,
    8'h00, 8'h2A, 8'h73, 8'h61, 8'h55, 8'h32,
    8'h3F, 8'h2F, 8'h27, 8'h23, 8'h21, 8'h20, 8'h30, 8'h38,
    8'h3C, 8'h3E,
    8'h78, 8'h00, 8'h00, 8'h31, 8'h00, 8'h4C, 8'h5A,
    8'h05, 8'h18, 8'h1A, 8'h0C, 8'h02, 8'h12, 8'h0E, 8'h10,
    8'h04, 8'h17, 8'h0D, 8'h14, 8'h07, 8'h06, 8'h0F, 8'h16,
    8'h1D, 8'h0A, 8'h08, 8'h03, 8'h09, 8'h11, 8'h0B, 8'h19,
    8'h1B, 8'h1C
  };

  typedef struct packed {
    logic                      key;
    logic [mmk_pkg::IDX_W-1:0] pos;
  } key_pos_t;

  logic clk = 1'b0;
  logic rst_n;

  mmk_in_if  in_ch();
  mmk_out_if out_ch();

  morse_message_keyer i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  mmk_pkg::entry_t cmd_queue[$];
  key_pos_t        key_pos_due[$];

  // Keyer state as predicted
  logic [mmk_pkg::CHR_W-1:0] msg_mem [0:mmk_pkg::MSG_DEPTH-1];
  logic [mmk_pkg::IDX_W-1:0] rd_pos;
  logic [mmk_pkg::CHR_W-1:0] pat;
  logic [mmk_pkg::TCK_W-1:0] elems;
  logic [mmk_pkg::TCK_W-1:0] tck;
  mmk_pkg::phase_t           ph;
  logic                      key;

  int err_count    = 0;
  int results_seen = 0;
  int accepted     = 0;
  int idle_level   = 0;
  int send_gap     = 0;
  int stall_left   = 0;
  int hold_left    = 0;
  bit held_once    = 1'b0;
  int cycle_cnt    = 0;

  function automatic void keyer_clear();
    for (int i = 0; i < mmk_pkg::MSG_DEPTH; i++) begin
      msg_mem[i] = '0;
    end
    rd_pos = '0;
    pat    = '0;
    elems  = '0;
    tck    = '0;
    ph     = mmk_pkg::PH_FETCH;
    key    = 1'b0;
  endfunction

  function automatic void keyer_tick();
    logic [mmk_pkg::CHR_W-1:0] ch;
    logic [mmk_pkg::CHR_W-1:0] code;
    int n;
    if (ph == mmk_pkg::PH_FETCH) begin
      if (msg_mem[rd_pos] == '0) begin
        rd_pos = '0;
      end
      ch = msg_mem[rd_pos];
      rd_pos = rd_pos + 1'b1;
      if (ch >= 8'h61 && ch <= 8'h7A) begin
        ch = ch - 8'h20;
      end
      code = '0;
      if (ch >= 8'h22 && ch <= 8'h5A) begin
        code = MORSE_PATTERNS[(56 - (int'(ch) - 'h22)) * 8 +: 8];
      end
      if (code == '0) begin
        tck   = mmk_pkg::WORD_GAP - 3'd2;
        elems = '0;
        ph    = mmk_pkg::PH_GAP;
        return;
      end
      n = 6;
      while (n > 1 && !code[n]) begin
        n--;
      end
      pat   = code << (8 - n);
      elems = mmk_pkg::TCK_W'(n);
      ph    = mmk_pkg::PH_START;
    end
    if (ph == mmk_pkg::PH_START) begin
      tck   = pat[7] ? mmk_pkg::DASH_TICKS : mmk_pkg::DOT_TICKS;
      pat   = pat << 1;
      elems = elems - 1'b1;
      key   = 1'b1;
      ph    = mmk_pkg::PH_SOUND;
    end
    if (ph == mmk_pkg::PH_SOUND) begin
      if (tck != '0) begin
        tck = tck - 1'b1;
        return;
      end
      ph  = mmk_pkg::PH_GAP;
      tck = (elems != '0) ? mmk_pkg::DOT_TICKS - 1'b1 : mmk_pkg::CHAR_GAP - 1'b1;
      key = 1'b0;
    end
    if (ph == mmk_pkg::PH_GAP) begin
      if (tck == '0) begin
        ph = (elems != '0) ? mmk_pkg::PH_START : mmk_pkg::PH_FETCH;
      end else begin
        tck = tck - 1'b1;
      end
    end
  endfunction

  function automatic key_pos_t predict_key_pos(mmk_pkg::entry_t c);
    key_pos_t r;
    case (c.op)
      mmk_pkg::OP_WRITE: begin
        if (int'(c.idx) < mmk_pkg::MSG_DEPTH) begin
          msg_mem[c.idx] = c.val;
        end
      end
      mmk_pkg::OP_RESTART: begin
        rd_pos = '0;
        ph     = mmk_pkg::PH_FETCH;
      end
      mmk_pkg::OP_TICK: begin
        keyer_tick();
      end
      default: begin
      end
    endcase
    r.key = key;
    r.pos = rd_pos;
    return r;
  endfunction

  function automatic void add_cmd(mmk_pkg::op_t op, logic [mmk_pkg::IDX_W-1:0] idx,
                                  logic [mmk_pkg::CHR_W-1:0] val);
    mmk_pkg::entry_t c;
    c.op  = op;
    c.idx = idx;
    c.val = val;
    cmd_queue.push_back(c);
  endfunction

  function automatic logic [mmk_pkg::CHR_W-1:0] msg_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'h41 + mmk_pkg::CHR_W'($urandom_range(0, 25));
      4, 5:       return 8'h61 + mmk_pkg::CHR_W'($urandom_range(0, 25));
      6, 7:       return mmk_pkg::CHR_W'($urandom_range('h22, 'h5A));
      8:          return mmk_pkg::CHR_W'($urandom_range(1, 255));
      default:    return $urandom_range(0, 1) ? 8'h45 : 8'h54;
    endcase
  endfunction

  // Mostly unmapped bytes so a full 64-character pass stays short
  function automatic logic [mmk_pkg::CHR_W-1:0] quick_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return mmk_pkg::CHR_W'($urandom_range('h80, 'hFF));
      4:          return mmk_pkg::CHR_W'($urandom_range('h01, 'h21));
      5:          return mmk_pkg::CHR_W'($urandom_range('h5B, 'h60));
      6:          return mmk_pkg::CHR_W'($urandom_range('h7B, 'h7F));
      7:          return 8'h45;
      8:          return 8'h74;
      default:    return 8'h65;
    endcase
  endfunction

  function automatic void add_ticks(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 90) begin
        add_cmd(mmk_pkg::OP_TICK, mmk_pkg::IDX_W'($urandom), mmk_pkg::CHR_W'($urandom));
      end else if (r < 94) begin
        add_cmd(mmk_pkg::OP_WRITE, mmk_pkg::IDX_W'($urandom_range(0, 63)),
                mmk_pkg::CHR_W'($urandom_range(0, 255)));
      end else if (r < 97) begin
        add_cmd(mmk_pkg::OP_RESTART, mmk_pkg::IDX_W'($urandom), mmk_pkg::CHR_W'($urandom));
      end else begin
        add_cmd(mmk_pkg::OP_NONE, mmk_pkg::IDX_W'($urandom), mmk_pkg::CHR_W'($urandom));
      end
    end
  endfunction

  function automatic bit idling_allowed();
    return idle_level != 0 && cmd_queue.size() >= 150;
  endfunction

  function automatic int idle_odds();
    return (idle_level == 1) ? 11 : 3;
  endfunction

  // Sender
  always @(posedge clk) begin
    mmk_pkg::entry_t nxt;
    if (!rst_n) begin
      in_ch.valid      <= 1'b0;
      in_ch.action     <= mmk_pkg::ACT_WRITE;
      in_ch.char_index <= '0;
      in_ch.char_value <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        nxt.op  = mmk_pkg::op_t'(in_ch.action);
        nxt.idx = in_ch.char_index;
        nxt.val = in_ch.char_value;
        key_pos_due.push_back(predict_key_pos(nxt));
        accepted++;
        if (accepted % 50 == 0) begin
          idle_level = $urandom_range(0, 2);
        end
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_ch.valid <= 1'b0;
        end else if (cmd_queue.size() != 0) begin
          nxt = cmd_queue.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.action     <= nxt.op;
          in_ch.char_index <= nxt.idx;
          in_ch.char_value <= nxt.val;
          if (idling_allowed() && $urandom_range(0, idle_odds()) == 0) begin
            send_gap = $urandom_range(1, 17);
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker
  always @(posedge clk) begin
    key_pos_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (key_pos_due.size() == 0) begin
          $error("unexpected transaction: key_down=%0d message_pos=%0d",
                 out_ch.key_down, out_ch.message_pos);
          err_count++;
        end else begin
          want = key_pos_due.pop_front();
          if (out_ch.key_down !== want.key) begin
            $error("key_down: expected %0d, got %0d", want.key, out_ch.key_down);
            err_count++;
          end
          if (out_ch.message_pos !== want.pos) begin
            $error("message_pos: expected %0d, got %0d", want.pos, out_ch.message_pos);
            err_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!held_once && results_seen >= 300) begin
        held_once = 1'b1;
        hold_left = 150;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (idling_allowed() && $urandom_range(0, idle_odds()) == 0) begin
          stall_left = $urandom_range(1, 17);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("morse_message_keyer_tb: errors");
      $finish;
    end
  end

  initial begin
    int len;
    bit full_done;
    rst_n     = 1'b0;
    full_done = 1'b0;
    keyer_clear();

    // Empty buffer gives word gaps, then an unused action code
    repeat (3) add_cmd(mmk_pkg::OP_TICK, 6'd0, 8'd0);
    add_cmd(mmk_pkg::OP_NONE, 6'd63, 8'hFF);
    // Case folding at both ends, table edges, neighbors just outside, longest patterns
    add_cmd(mmk_pkg::OP_WRITE, 6'd0, 8'h61);
    add_cmd(mmk_pkg::OP_WRITE, 6'd1, 8'h7A);
    add_cmd(mmk_pkg::OP_WRITE, 6'd2, 8'h22);
    add_cmd(mmk_pkg::OP_WRITE, 6'd3, 8'h5A);
    add_cmd(mmk_pkg::OP_WRITE, 6'd4, 8'h21);
    add_cmd(mmk_pkg::OP_WRITE, 6'd5, 8'h5B);
    add_cmd(mmk_pkg::OP_WRITE, 6'd6, 8'h30);
    add_cmd(mmk_pkg::OP_WRITE, 6'd7, 8'h27);
    add_cmd(mmk_pkg::OP_WRITE, 6'd8, 8'hFF);
    add_cmd(mmk_pkg::OP_WRITE, 6'd63, 8'h45);
    add_cmd(mmk_pkg::OP_WRITE, 6'd9, 8'h00);
    repeat (6) add_cmd(mmk_pkg::OP_TICK, 6'd0, 8'd0);
    add_cmd(mmk_pkg::OP_RESTART, 6'd63, 8'hFF);
    repeat (3) add_cmd(mmk_pkg::OP_TICK, 6'd0, 8'd0);

    while (cmd_queue.size() < TARGET_CMDS) begin
      if (!full_done && cmd_queue.size() > 250) begin
        // No terminator anywhere: read position must wrap from the last entry
        full_done = 1'b1;
        for (int i = 0; i < mmk_pkg::MSG_DEPTH; i++) begin
          add_cmd(mmk_pkg::OP_WRITE, mmk_pkg::IDX_W'(i), quick_char());
        end
        add_cmd(mmk_pkg::OP_RESTART, 6'd0, 8'd0);
        repeat (340) add_cmd(mmk_pkg::OP_TICK, mmk_pkg::IDX_W'($urandom),
                             mmk_pkg::CHR_W'($urandom));
      end else begin
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) begin
          add_cmd(mmk_pkg::OP_WRITE, mmk_pkg::IDX_W'(i), msg_char());
        end
        add_cmd(mmk_pkg::OP_WRITE, mmk_pkg::IDX_W'(len), 8'h00);
        if ($urandom_range(0, 1)) begin
          add_cmd(mmk_pkg::OP_RESTART, mmk_pkg::IDX_W'($urandom), mmk_pkg::CHR_W'($urandom));
        end
        add_ticks($urandom_range(30, 120));
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_queue.size() != 0 || in_ch.valid || key_pos_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("morse_message_keyer_tb: clean");
    end else begin
      $display("morse_message_keyer_tb: errors");
    end
    $finish;
  end

endmodule

[files.f]
rtl/mmk_pkg.sv
rtl/mmk_if.sv
rtl/mmk_ram.sv
rtl/mmk_front.sv
rtl/mmk_queue.sv
rtl/mmk_back.sv
rtl/morse_message_keyer.sv
rtl/mmk_checker.sv
verif/morse_message_keyer_tb.sv
